// ===== hw/rtl/shash_pkg.sv =====
// Shared constants, codes and types of the spatial hash grid insert block.
`default_nettype none

package shash_pkg;

  localparam int unsigned BUCKETS_DEF       = 256;
  localparam int unsigned BUCKET_SLOTS_DEF  = 8;
  localparam int unsigned MAX_COLLIDERS_DEF = 1024;
  localparam int unsigned MAX_SPAN_DEF      = 4;

  localparam logic [31:0] HASH_PX        = 32'd73856093;
  localparam logic [31:0] HASH_PY        = 32'd19349663;
  localparam logic [31:0] CELL_RECIP_RST = 32'd65536;

  localparam int unsigned PADDR_W = 3;
  // register index sits above the byte offset
  localparam logic REG_CELL_RECIP = 1'b0;

  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_NOCELL  = 2'd2;

  typedef enum logic [1:0] {
    MUL_SCALE,
    MUL_HASH_X,
    MUL_HASH_Y
  } mul_op_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_SCALE,
    S_CHECK,
    S_HASH_X,
    S_HASH_Y,
    S_READ,
    S_UPDATE,
    S_EMPTY
  } seq_state_t;

  typedef struct packed {
    logic fill_rd;
    logic fill_wr;
    logic item_wr;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shash_if.sv =====
// Request and result channel interfaces of the spatial hash grid insert block.
`default_nettype none

interface shash_item_if #(
  parameter int ID_W = 10
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [ID_W-1:0]        collider_id;
  logic signed [31:0]     min_x;
  logic signed [31:0]     min_y;
  logic signed [31:0]     max_x;
  logic signed [31:0]     max_y;

  modport source (
    output valid, operation, collider_id, min_x, min_y, max_x, max_y,
    input  ready
  );
  modport sink (
    input  valid, operation, collider_id, min_x, min_y, max_x, max_y,
    output ready
  );
endinterface

interface shash_result_if #(
  parameter int BIDX_W = 8,
  parameter int SLOT_W = 3
);
  logic                   valid;
  logic                   ready;
  logic [BIDX_W-1:0]      bucket_index;
  logic [SLOT_W-1:0]      slot;
  logic signed [31:0]     cell_x;
  logic signed [31:0]     cell_y;
  logic [1:0]             status;
  logic                   clipped;
  logic                   last;

  modport source (
    output valid, bucket_index, slot, cell_x, cell_y, status, clipped, last,
    input  ready
  );
  modport sink (
    input  valid, bucket_index, slot, cell_x, cell_y, status, clipped, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/shash_apb.sv =====
// APB configuration register file: cell size reciprocal.
`default_nettype none

module shash_apb
  import shash_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [31:0]        cell_recip
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_CELL_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_recip <= CELL_RECIP_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      cell_recip <= pwdata;
    end
  end

  assign prdata = hit ? cell_recip : 32'd0;

endmodule

`default_nettype wire

// ===== hw/rtl/shash_mul.sv =====
// Shared registered multiplier: corner scaling and cell hashing.
`default_nettype none

module shash_mul
  import shash_pkg::*;
(
  input  wire logic               clk,
  input  wire mul_op_t            op,
  input  wire logic signed [31:0] value,
  input  wire logic        [31:0] recip,
  output logic signed      [65:0] prod
);

  logic [31:0] coef;

  always_comb begin
    unique case (op)
      MUL_SCALE:  coef = recip;
      MUL_HASH_X: coef = HASH_PX;
      MUL_HASH_Y: coef = HASH_PY;
      default:    coef = HASH_PX;
    endcase
  end

  // low bits give the hash, bits 63:32 give the floored cell
  always_ff @(posedge clk) begin
    prod <= $signed({value[31], value}) * $signed({1'b0, coef});
  end

endmodule

`default_nettype wire

// ===== hw/rtl/shash_mem.sv =====
// Bucket fill counts and bucket entry storage.
`default_nettype none

module shash_mem
  import shash_pkg::*;
#(
  parameter int BUCKETS      = BUCKETS_DEF,
  parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF,
  parameter int BIDX_W       = 8,
  parameter int SLOT_W       = 3,
  parameter int FILL_W       = 4,
  parameter int ID_W         = 10
) (
  input  wire logic              clk,
  input  wire mem_ctrl_t         ctrl,
  input  wire logic [BIDX_W-1:0] addr,
  input  wire logic [FILL_W-1:0] wr_fill,
  input  wire logic [SLOT_W-1:0] item_slot,
  input  wire logic [ID_W-1:0]   item_id,
  output logic      [FILL_W-1:0] rd_fill
);

  localparam int ITEMS   = BUCKETS * BUCKET_SLOTS;
  localparam int IIDX_W  = (ITEMS > 1) ? $clog2(ITEMS) : 1;

  logic [FILL_W-1:0] fill_mem [BUCKETS];
  logic [ID_W-1:0]   item_mem [ITEMS];
  logic [IIDX_W-1:0] item_addr;

  assign item_addr = IIDX_W'(IIDX_W'(addr) * IIDX_W'(BUCKET_SLOTS) + IIDX_W'(item_slot));

  always_ff @(posedge clk) begin
    if (ctrl.fill_wr) begin
      fill_mem[addr] <= wr_fill;
    end
    if (ctrl.fill_rd) begin
      rd_fill <= fill_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.item_wr) begin
      item_mem[item_addr] <= item_id;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/shash_seq.sv =====
// Sequencer: corner scaling, span walk, bucket update and result register.
`default_nettype none

module shash_seq
  import shash_pkg::*;
#(
  parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF,
  parameter int MAX_SPAN     = MAX_SPAN_DEF,
  parameter int BIDX_W       = 8,
  parameter int SLOT_W       = 3,
  parameter int FILL_W       = 4,
  parameter int ID_W         = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  shash_item_if.sink              item,
  shash_result_if.source          result,
  output mul_op_t                 mul_op,
  output logic signed [31:0]      mul_value,
  input  wire logic signed [65:0] prod,
  output mem_ctrl_t               ctrl,
  output logic [BIDX_W-1:0]       mem_addr,
  output logic [FILL_W-1:0]       wr_fill,
  output logic [SLOT_W-1:0]       item_slot,
  output logic [ID_W-1:0]         item_id,
  input  wire logic [FILL_W-1:0]  rd_fill
);

  localparam int SPAN_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

  seq_state_t state, state_next;

  logic [2:0]          scnt;
  logic [BIDX_W-1:0]   sweep_cnt;
  logic                sweep_emit;
  logic                res_valid;
  logic                res_load;
  logic                res_free;

  logic [ID_W-1:0]     id_r;
  logic signed [31:0]  corner_raw [4];
  logic signed [31:0]  cpos [4];
  logic signed [31:0]  cur_x, cur_y;
  logic [SPAN_W-1:0]   ix, iy, nx, ny;
  logic                clip;
  logic [BIDX_W-1:0]   hx, bucket;

  logic signed [32:0]  dx, dy;
  logic                empty_box;
  logic                clip_x, clip_y;
  logic                stored;
  logic                last_cell;

  logic [BIDX_W-1:0]   res_bucket;
  logic [SLOT_W-1:0]   res_slot;
  logic signed [31:0]  res_cx, res_cy;
  logic [1:0]          res_status;
  logic                res_clip;
  logic                res_last;

  assign res_free  = !res_valid || result.ready;
  assign dx        = $signed({cpos[2][31], cpos[2]}) - $signed({cpos[0][31], cpos[0]});
  assign dy        = $signed({cpos[3][31], cpos[3]}) - $signed({cpos[1][31], cpos[1]});
  assign empty_box = dx[32] || dy[32];
  assign clip_x    = (dx >= $signed(33'(MAX_SPAN)));
  assign clip_y    = (dy >= $signed(33'(MAX_SPAN)));
  assign stored    = (rd_fill < FILL_W'(BUCKET_SLOTS));
  assign last_cell = (ix == nx) && (iy == ny);
  assign item_slot = SLOT_W'(rd_fill);
  assign item_id   = id_r;
  assign wr_fill   = (state == S_SWEEP) ? '0 : FILL_W'(rd_fill + 1'b1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_cnt == {BIDX_W{1'b1}}) begin
          state_next = sweep_emit ? S_EMPTY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item.valid) begin
          state_next = (item.operation == OP_CLEAR) ? S_SWEEP : S_SCALE;
        end
      end
      S_SCALE: begin
        if (scnt == 3'd4) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = empty_box ? S_EMPTY : S_HASH_X;
      S_HASH_X: state_next = S_HASH_Y;
      S_HASH_Y: state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: begin
        if (res_free) begin
          state_next = last_cell ? S_IDLE : S_HASH_X;
        end
      end
      S_EMPTY: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = 1'b0;
    ctrl       = '0;
    mem_addr   = bucket;
    mul_op     = MUL_SCALE;
    mul_value  = cur_x;
    res_load   = 1'b0;
    unique case (state)
      S_SWEEP: begin
        ctrl.fill_wr = 1'b1;
        mem_addr     = sweep_cnt;
      end
      S_IDLE:  item.ready = 1'b1;
      S_SCALE: begin
        mul_op    = MUL_SCALE;
        mul_value = corner_raw[scnt[1:0]];
      end
      S_CHECK: ;
      S_HASH_X: begin
        mul_op    = MUL_HASH_X;
        mul_value = cur_x;
      end
      S_HASH_Y: begin
        mul_op    = MUL_HASH_Y;
        mul_value = cur_y;
      end
      S_READ: begin
        ctrl.fill_rd = 1'b1;
        mem_addr     = hx ^ prod[BIDX_W-1:0];
      end
      S_UPDATE: begin
        // write and emit in the same cycle so a stall leaves the bucket untouched
        if (res_free) begin
          res_load     = 1'b1;
          ctrl.fill_wr = stored;
          ctrl.item_wr = stored;
        end
      end
      S_EMPTY: res_load = res_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      scnt       <= '0;
      sweep_cnt  <= '0;
      sweep_emit <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        scnt <= '0;
      end else if (state == S_SCALE) begin
        scnt <= scnt + 3'd1;
      end
      if (state == S_SWEEP) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (state == S_IDLE && item.valid) begin
        sweep_emit <= (item.operation == OP_CLEAR);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid) begin
      id_r          <= item.collider_id;
      corner_raw[0] <= item.min_x;
      corner_raw[1] <= item.min_y;
      corner_raw[2] <= item.max_x;
      corner_raw[3] <= item.max_y;
    end
    if (state == S_SCALE && scnt != 3'd0) begin
      cpos[2'(scnt - 3'd1)] <= prod[63:32];
    end
    if (state == S_CHECK) begin
      cur_x <= cpos[0];
      cur_y <= cpos[1];
      ix    <= '0;
      iy    <= '0;
      nx    <= clip_x ? SPAN_W'(MAX_SPAN - 1) : dx[SPAN_W-1:0];
      ny    <= clip_y ? SPAN_W'(MAX_SPAN - 1) : dy[SPAN_W-1:0];
      clip  <= clip_x || clip_y;
    end
    if (state == S_HASH_Y) begin
      hx <= prod[BIDX_W-1:0];
    end
    if (state == S_READ) begin
      bucket <= mem_addr;
    end
    // advance row by row, x inner
    if (state == S_UPDATE && res_free) begin
      if (ix == nx) begin
        ix    <= '0;
        cur_x <= cpos[0];
        iy    <= iy + 1'b1;
        cur_y <= cur_y + 32'sd1;
      end else begin
        ix    <= ix + 1'b1;
        cur_x <= cur_x + 32'sd1;
      end
    end
    if (res_load) begin
      if (state == S_UPDATE) begin
        res_bucket <= bucket;
        res_slot   <= stored ? SLOT_W'(rd_fill) : '0;
        res_cx     <= cur_x;
        res_cy     <= cur_y;
        res_status <= stored ? ST_STORED : ST_DROPPED;
        res_clip   <= clip;
        res_last   <= last_cell;
      end else begin
        res_bucket <= '0;
        res_slot   <= '0;
        res_cx     <= '0;
        res_cy     <= '0;
        res_status <= ST_NOCELL;
        res_clip   <= 1'b0;
        res_last   <= 1'b1;
      end
    end
  end

  assign result.valid        = res_valid;
  assign result.bucket_index = res_bucket;
  assign result.slot         = res_slot;
  assign result.cell_x       = res_cx;
  assign result.cell_y       = res_cy;
  assign result.status       = res_status;
  assign result.clipped      = res_clip;
  assign result.last         = res_last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("request taken while a previous one is in progress");

  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.fill_rd && ctrl.fill_wr))
    else $error("fill memory read and written in one cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || result.ready))
    else $error("result register overwritten before it was taken");

  a_nocell_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_NOCELL) |-> res_last)
    else $error("no-cell result without last");

endmodule

`default_nettype wire

// ===== hw/rtl/spatial_hash_grid_insert.sv =====
// Insert: an accepted request is scaled corner by corner and span checked, then each
// visited cell takes hash x, hash y, fill read and fill write in turn; the shared
// multiplier and the single-port fill memory keep these steps apart. Up to MAX_SPAN^2 results.
// Clear: a sweep over every bucket of the fill memory, then one result.
// Reset (synchronous, active high) starts the same sweep with ready low;
// the cell_recip register returns to 1.0 and the result register empties.
`default_nettype none

module spatial_hash_grid_insert
  import shash_pkg::*;
#(
  parameter int BUCKETS       = BUCKETS_DEF,
  parameter int BUCKET_SLOTS  = BUCKET_SLOTS_DEF,
  parameter int MAX_COLLIDERS = MAX_COLLIDERS_DEF,
  parameter int MAX_SPAN      = MAX_SPAN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  shash_item_if.sink              item,
  shash_result_if.source          result
);

  localparam int BIDX_W = $clog2(BUCKETS);
  localparam int SLOT_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
  localparam int ID_W   = $clog2(MAX_COLLIDERS);

  logic [31:0]         cell_recip;
  mul_op_t             mul_op;
  logic signed [31:0]  mul_value;
  logic signed [65:0]  prod;
  mem_ctrl_t           ctrl;
  logic [BIDX_W-1:0]   mem_addr;
  logic [FILL_W-1:0]   wr_fill;
  logic [FILL_W-1:0]   rd_fill;
  logic [SLOT_W-1:0]   item_slot;
  logic [ID_W-1:0]     item_id;

  shash_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cell_recip (cell_recip)
  );

  shash_mul u_mul (
    .clk   (clk),
    .op    (mul_op),
    .value (mul_value),
    .recip (cell_recip),
    .prod  (prod)
  );

  shash_mem #(
    .BUCKETS      (BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .BIDX_W       (BIDX_W),
    .SLOT_W       (SLOT_W),
    .FILL_W       (FILL_W),
    .ID_W         (ID_W)
  ) u_mem (
    .clk       (clk),
    .ctrl      (ctrl),
    .addr      (mem_addr),
    .wr_fill   (wr_fill),
    .item_slot (item_slot),
    .item_id   (item_id),
    .rd_fill   (rd_fill)
  );

  shash_seq #(
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .MAX_SPAN     (MAX_SPAN),
    .BIDX_W       (BIDX_W),
    .SLOT_W       (SLOT_W),
    .FILL_W       (FILL_W),
    .ID_W         (ID_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .mul_op    (mul_op),
    .mul_value (mul_value),
    .prod      (prod),
    .ctrl      (ctrl),
    .mem_addr  (mem_addr),
    .wr_fill   (wr_fill),
    .item_slot (item_slot),
    .item_id   (item_id),
    .rd_fill   (rd_fill)
  );

endmodule

`default_nettype wire

// ===== dv/tb_spatial_hash_grid_insert.sv =====
// Testbench for spatial_hash_grid_insert: box requests checked against a bucket-fill model.
`timescale 1ns / 1ps

module tb_spatial_hash_grid_insert;
  import shash_pkg::*;

  localparam int     STALL_LIMIT  = 4000;
  localparam int     PHASE_ITEMS  = 62;
  localparam longint SPAN_CELLS   = MAX_SPAN_DEF;

  typedef struct packed {
    logic        operation;
    logic [9:0]  collider_id;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] max_x;
    logic [31:0] max_y;
  } box_request_t;

  typedef struct packed {
    logic [7:0]  bucket_index;
    logic [2:0]  slot;
    logic [31:0] cell_x;
    logic [31:0] cell_y;
    logic [1:0]  status;
    logic        clipped;
    logic        last;
  } cell_result_t;

  typedef struct {
    box_request_t rq;
    bit           typed;
    cell_result_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               res_ready = 1'b0;

  shash_item_if #(.ID_W(10)) item_ch ();
  shash_result_if #(.BIDX_W(8), .SLOT_W(3)) result_ch ();

  assign result_ch.ready = res_ready;

  spatial_hash_grid_insert u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  always #4 clk = ~clk;

  // model state
  logic [31:0]  cell_recip_q = CELL_RECIP_RST;
  logic [3:0]   bucket_level [BUCKETS_DEF];
  cell_result_t pending_cells [$];
  stim_row_t    directed_rows [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int ready_hold  = 0;
  bit idle_on     = 1'b1;

  initial begin
    foreach (bucket_level[i]) bucket_level[i] = '0;
  end

  function automatic longint floor_cell(logic [31:0] raw);
    longint prod;
    prod = longint'($signed(raw)) * longint'({32'd0, cell_recip_q});
    return prod >>> 32;
  endfunction

  function automatic logic [31:0] to_q16(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Append one expected result to the tail of the pending list.
  function automatic void queue_cell(cell_result_t res);
    pending_cells = {pending_cells, res};
  endfunction

  // Bin one request into the bucket model; queue its cells when record is set.
  function automatic void bin_box(box_request_t rq, bit record);
    longint       x0, y0, x1, y1;
    logic         clip;
    logic [31:0]  hash;
    logic [7:0]   bidx;
    cell_result_t res;
    res = '0;
    if (rq.operation == OP_CLEAR) begin
      foreach (bucket_level[i]) bucket_level[i] = '0;
      res.status = ST_NOCELL;
      res.last   = 1'b1;
      if (record) queue_cell(res);
      return;
    end
    x0 = floor_cell(rq.min_x);
    y0 = floor_cell(rq.min_y);
    x1 = floor_cell(rq.max_x);
    y1 = floor_cell(rq.max_y);
    if (x1 < x0 || y1 < y0) begin
      res.status = ST_NOCELL;
      res.last   = 1'b1;
      if (record) queue_cell(res);
      return;
    end
    clip = 1'b0;
    if (x1 - x0 + 1 > SPAN_CELLS) begin
      x1   = x0 + SPAN_CELLS - 1;
      clip = 1'b1;
    end
    if (y1 - y0 + 1 > SPAN_CELLS) begin
      y1   = y0 + SPAN_CELLS - 1;
      clip = 1'b1;
    end
    for (longint y = y0; y <= y1; y++) begin
      for (longint x = x0; x <= x1; x++) begin
        hash = (x[31:0] * HASH_PX) ^ (y[31:0] * HASH_PY);
        bidx = 8'(hash & (BUCKETS_DEF - 1));
        res.bucket_index = bidx;
        res.cell_x       = x[31:0];
        res.cell_y       = y[31:0];
        res.clipped      = clip;
        res.last         = (x == x1 && y == y1);
        if (bucket_level[bidx] < BUCKET_SLOTS_DEF) begin
          res.slot           = bucket_level[bidx][2:0];
          res.status         = ST_STORED;
          bucket_level[bidx] = bucket_level[bidx] + 4'd1;
        end else begin
          res.slot   = '0;
          res.status = ST_DROPPED;
        end
        if (record) queue_cell(res);
      end
    end
  endfunction

  function automatic void add_row(logic op, logic [9:0] id, logic [31:0] mnx, logic [31:0] mny,
                                  logic [31:0] mxx, logic [31:0] mxy, bit typed,
                                  logic [2:0] slot, logic [1:0] st);
    stim_row_t row;
    row.rq          = {op, id, mnx, mny, mxx, mxy};
    row.typed       = typed;
    row.want        = '0;
    row.want.slot   = slot;
    row.want.status = st;
    row.want.last   = 1'b1;
    directed_rows   = {directed_rows, row};
  endfunction

  // Mostly well-formed small boxes around the origin, some noise, empty boxes and clears.
  function automatic box_request_t random_box();
    box_request_t rq;
    int unsigned  pick;
    int           cx, cy;
    longint       cell_span, base_x, base_y, sx, sy;
    rq.operation   = OP_INSERT;
    rq.collider_id = 10'($urandom_range(0, 1023));
    rq.min_x       = $urandom;
    rq.min_y       = $urandom;
    rq.max_x       = $urandom;
    rq.max_y       = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      rq.operation = OP_CLEAR;
    end else if (pick >= 10) begin
      cell_span = longint'(64'h1_0000_0000) / longint'({32'd0, cell_recip_q});
      cx = int'($urandom_range(0, 12)) - 6;
      cy = int'($urandom_range(0, 12)) - 6;
      base_x = cx * cell_span + longint'($urandom) % cell_span;
      base_y = cy * cell_span + longint'($urandom) % cell_span;
      sx = $urandom_range(0, 3);
      sy = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) sx = $urandom_range(4, 6);
      if ($urandom_range(0, 7) == 0) sy = $urandom_range(4, 6);
      rq.min_x = to_q16(base_x);
      rq.min_y = to_q16(base_y);
      rq.max_x = to_q16(base_x + sx * cell_span);
      rq.max_y = to_q16(base_y + sy * cell_span);
      // flip one axis so the box is inside out
      if (pick < 16) begin
        if ($urandom_range(0, 1) == 0) rq.max_x = to_q16(base_x - cell_span);
        else rq.max_y = to_q16(base_y - cell_span);
      end
    end
    return rq;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_cells.size() == 0) begin
        $error("result with nothing pending: bucket_index %0d cell (%0d, %0d)",
               result_ch.bucket_index, result_ch.cell_x, result_ch.cell_y);
        mismatches++;
      end else begin
        want = pending_cells.pop_front();
        check_field("bucket_index", want.bucket_index, result_ch.bucket_index);
        check_field("slot", want.slot, result_ch.slot);
        check_field("cell_x", longint'($signed(want.cell_x)), longint'(result_ch.cell_x));
        check_field("cell_y", longint'($signed(want.cell_y)), longint'(result_ch.cell_y));
        check_field("status", want.status, result_ch.status);
        check_field("clipped", want.clipped, result_ch.clipped);
        check_field("last", want.last, result_ch.last);
      end
    end
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      res_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      res_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 23);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_spatial_hash_grid_insert: done, errors");
    $finish;
  end

  task automatic wait_drain();
    do @(posedge clk); while (pending_cells.size() != 0);
  endtask

  // Write cell_recip, then read it back in the same select.
  task automatic write_cell_recip(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_CELL_RECIP, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cell_recip_q = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("cell_recip", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_request(stim_row_t row);
    item_ch.operation   <= row.rq.operation;
    item_ch.collider_id <= row.rq.collider_id;
    item_ch.min_x       <= row.rq.min_x;
    item_ch.min_y       <= row.rq.min_y;
    item_ch.max_x       <= row.rq.max_x;
    item_ch.max_y       <= row.rq.max_y;
    item_ch.valid       <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    bin_box(row.rq, !row.typed);
    if (row.typed) queue_cell(row.want);
  endtask

  // Gap after a request: an idle burst, or now and then a full drain.
  task automatic pace_sender();
    if ($urandom_range(0, 39) == 0) begin
      item_ch.valid <= 1'b0;
      wait_drain();
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin
    stim_row_t   row;
    logic [31:0] phase_recip [5];

    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.operation   <= OP_CLEAR;
    item_ch.collider_id <= '0;
    item_ch.min_x       <= '0;
    item_ch.min_y       <= '0;
    item_ch.max_x       <= '0;
    item_ch.max_y       <= '0;

    phase_recip[0] = CELL_RECIP_RST;
    phase_recip[1] = 32'd1;
    phase_recip[2] = 32'hFFFF_FFFF;
    phase_recip[3] = $urandom_range(32'h0000_4000, 32'h0004_0000);
    phase_recip[4] = $urandom;
    if (phase_recip[4] == 0) phase_recip[4] = 32'd1;

    // cell (0,0) hashes to bucket 0: fill it, overflow it, clear it
    add_row(OP_CLEAR, 10'd0, 0, 0, 0, 0, 1, 3'd0, ST_NOCELL);
    add_row(OP_INSERT, 10'd0, 0, 0, 0, 0, 1, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'd1023, 32'h0000_8000, 32'h0000_8000, 32'h0000_C000, 32'h0000_E666,
            1, 3'd1, ST_STORED);
    for (int s = 2; s < BUCKET_SLOTS_DEF; s++) begin
      add_row(OP_INSERT, 10'(s * 100), 32'h0000_4000, 0, 32'h0000_4000, 32'h0000_FFFF,
              1, 3'(s), ST_STORED);
    end
    add_row(OP_INSERT, 10'd777, 0, 0, 0, 0, 1, 3'd0, ST_DROPPED);
    add_row(OP_INSERT, 10'd3, 32'h0002_0000, 0, 32'h0001_0000, 0, 1, 3'd0, ST_NOCELL);
    add_row(OP_INSERT, 10'd4, 0, 0, 0, 32'hFFFF_8000, 1, 3'd0, ST_NOCELL);
    add_row(OP_INSERT, 10'd5, 32'hFFFE_8000, 32'hFFFD_C000, 32'h0000_4000, 0, 0, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'd6, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            0, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            0, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'd8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            0, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'd9, 32'h000A_0000, 32'h0003_0000, 32'h000D_FFFF, 32'h0003_0000,
            0, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'h2AA, 32'h0014_0000, 0, 32'h0018_0000, 0, 0, 3'd0, ST_STORED);
    add_row(OP_INSERT, 10'h155, 0, 32'h001E_0000, 0, 32'h0022_8000, 0, 3'd0, ST_STORED);
    add_row(OP_CLEAR, 10'd0, 0, 0, 0, 0, 1, 3'd0, ST_NOCELL);
    add_row(OP_INSERT, 10'd1, 0, 0, 0, 0, 1, 3'd0, ST_STORED);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      idle_on = (phase != 2 && phase != 4);
      if (phase != 0) begin
        item_ch.valid <= 1'b0;
        wait_drain();
        repeat (16) @(posedge clk);
      end
      write_cell_recip(phase_recip[phase]);
      if (phase == 0) begin
        foreach (directed_rows[i]) begin
          push_request(directed_rows[i]);
          pace_sender();
        end
      end
      repeat (PHASE_ITEMS) begin
        row.rq    = random_box();
        row.typed = 1'b0;
        row.want  = '0;
        push_request(row);
        pace_sender();
      end
    end

    item_ch.valid <= 1'b0;
    wait_drain();
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_spatial_hash_grid_insert: done, clean");
    end else begin
      $display("tb_spatial_hash_grid_insert: done, errors");
    end
    $finish;
  end

endmodule
